>>> rtl/core/version_string_parser_unit_assert.svh
// Assertion macros used by the checker of this block.
`ifndef VERSION_STRING_PARSER_UNIT_ASSERT_SVH
`define VERSION_STRING_PARSER_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define VSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked while reset is held.
`define VSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/vsp_pkg.sv
package vsp_pkg;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_B    = 8'h62;

    // field position within the string
    typedef enum logic [2:0] {
        IDX_MAJOR,
        IDX_MINOR,
        IDX_PATCH,
        IDX_FULL,
        IDX_PRE,
        IDX_PAST
    } vsp_idx_t;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_A,
        TAG_B
    } vsp_tag_t;

    // one character handed to the parse stage
    typedef struct packed {
        logic       step;
        logic [7:0] ch;
    } vsp_cmd_t;

endpackage

>>> rtl/core/vsp_parse.sv
module vsp_parse #(
    parameter int NUM_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vsp_pkg::vsp_cmd_t     cmd,
    output logic                  res_ok,
    output logic [NUM_BITS-1:0]   res_major,
    output logic [NUM_BITS-1:0]   res_minor,
    output logic [NUM_BITS-1:0]   res_patch,
    output vsp_pkg::vsp_tag_t     res_pretag,
    output logic [NUM_BITS-1:0]   res_prenum
);
    import vsp_pkg::*;

    logic [NUM_BITS-1:0] accum_reg, accum_next;
    logic                digit_seen_reg, digit_seen_next;
    vsp_idx_t            idx_reg, idx_next;
    logic [NUM_BITS-1:0] major_reg, major_next;
    logic [NUM_BITS-1:0] minor_reg, minor_next;
    logic [NUM_BITS-1:0] patch_reg, patch_next;
    logic [NUM_BITS-1:0] prenum_reg, prenum_next;
    vsp_tag_t            tag_reg, tag_next;
    logic                err_reg, err_next;

    logic                is_dot;
    logic                is_tag;
    logic                is_digit;
    logic [3:0]          digit_val;
    logic [NUM_BITS+3:0] accum_x10;
    logic [NUM_BITS+3:0] accum_new;
    logic                ovf;
    logic                good;

    assign is_dot    = (cmd.ch == CH_DOT);
    assign is_tag    = (cmd.ch == CH_A) || (cmd.ch == CH_B);
    assign is_digit  = (cmd.ch >= CH_ZERO) && (cmd.ch <= CH_NINE);
    assign digit_val = 4'(cmd.ch - CH_ZERO);
    // times ten as shift and add
    assign accum_x10 = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0};
    assign accum_new = accum_x10 + {{NUM_BITS{1'b0}}, digit_val};
    assign ovf       = |accum_new[NUM_BITS+3:NUM_BITS];

    always_comb
    begin
        accum_next      = accum_reg;
        digit_seen_next = digit_seen_reg;
        idx_next        = idx_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        patch_next      = patch_reg;
        prenum_next     = prenum_reg;
        tag_next        = tag_reg;
        err_next        = err_reg;
        if (cmd.step)
        begin
            if (cmd.ch == CH_NUL)
            begin
                accum_next      = '0;
                digit_seen_next = 1'b0;
                idx_next        = IDX_MAJOR;
                major_next      = '0;
                minor_next      = '0;
                patch_next      = '0;
                prenum_next     = '0;
                tag_next        = TAG_NONE;
                err_next        = 1'b0;
            end
            else if (!err_reg)
            begin
                if (idx_reg >= IDX_PAST)
                begin
                    err_next = 1'b1;
                end
                else if (is_dot || is_tag)
                begin
                    if (!digit_seen_reg || (is_tag && (idx_reg > IDX_FULL)))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        case (idx_reg)
                            IDX_MAJOR: major_next  = accum_reg;
                            IDX_MINOR: minor_next  = accum_reg;
                            IDX_PATCH: patch_next  = accum_reg;
                            IDX_PRE:   prenum_next = accum_reg;
                            default:   ;
                        endcase
                        accum_next      = '0;
                        digit_seen_next = 1'b0;
                        if (is_tag)
                        begin
                            tag_next = (cmd.ch == CH_A) ? TAG_A : TAG_B;
                            idx_next = IDX_PRE;
                        end
                        else
                        begin
                            idx_next = vsp_idx_t'(idx_reg + 3'd1);
                        end
                    end
                end
                else if (is_digit)
                begin
                    if ((idx_reg == IDX_FULL) || ovf)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        accum_next      = accum_new[NUM_BITS-1:0];
                        digit_seen_next = 1'b1;
                    end
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg      <= '0;
            digit_seen_reg <= 1'b0;
            idx_reg        <= IDX_MAJOR;
            major_reg      <= '0;
            minor_reg      <= '0;
            patch_reg      <= '0;
            prenum_reg     <= '0;
            tag_reg        <= TAG_NONE;
            err_reg        <= 1'b0;
        end
        else
        begin
            accum_reg      <= accum_next;
            digit_seen_reg <= digit_seen_next;
            idx_reg        <= idx_next;
            major_reg      <= major_next;
            minor_reg      <= minor_next;
            patch_reg      <= patch_next;
            prenum_reg     <= prenum_next;
            tag_reg        <= tag_next;
            err_reg        <= err_next;
        end
    end

    // result as closed by a terminator in this cycle
    assign good       = !err_reg && digit_seen_reg && (idx_reg < IDX_PAST);
    assign res_ok     = good;
    assign res_major  = !good ? '0 : ((idx_reg == IDX_MAJOR) ? accum_reg : major_reg);
    assign res_minor  = !good ? '0 : ((idx_reg == IDX_MINOR) ? accum_reg : minor_reg);
    assign res_patch  = !good ? '0 : ((idx_reg == IDX_PATCH) ? accum_reg : patch_reg);
    assign res_pretag = !good ? TAG_NONE : tag_reg;
    assign res_prenum = !good ? '0 : ((idx_reg == IDX_PRE) ? accum_reg : prenum_reg);

endmodule

>>> rtl/core/version_string_parser_unit.sv
// A terminator word shows on m_axis after it passes the input register and then the result register.
// Throughput: one word per cycle while no terminator waits; the parse step is one compare and times-ten add per cycle.
// A terminator waits in the input register only while an earlier result is still unread.
// Reset (rst_n low, asynchronous) clears the parse state and the valid flags of both stages.
module version_string_parser_unit #(
    parameter  int NUM_BITS = 16,
    localparam int OUT_W    = ((4 * NUM_BITS + 2 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // ch
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // major, minor, patch, pretag, prenum, zero pad
    output logic             m_axis_tuser    // ok
);
    import vsp_pkg::*;

    localparam int PAY_W = 4 * NUM_BITS + 2;

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_ch_reg;
    logic                out_valid_reg, out_valid_next;
    logic [PAY_W-1:0]    out_data_reg;
    logic                out_ok_reg;

    logic                in_term;
    logic                proc_ready;
    logic                fire;
    vsp_cmd_t            cmd;

    logic                res_ok;
    logic [NUM_BITS-1:0] res_major;
    logic [NUM_BITS-1:0] res_minor;
    logic [NUM_BITS-1:0] res_patch;
    vsp_tag_t            res_pretag;
    logic [NUM_BITS-1:0] res_prenum;

    assign in_term       = (in_ch_reg == CH_NUL);
    assign proc_ready    = !in_term || !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && proc_ready;
    assign s_axis_tready = !in_valid_reg || fire;

    assign cmd.step = fire;
    assign cmd.ch   = in_ch_reg;

    vsp_parse #(
        .NUM_BITS (NUM_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res_ok     (res_ok),
        .res_major  (res_major),
        .res_minor  (res_minor),
        .res_patch  (res_patch),
        .res_pretag (res_pretag),
        .res_prenum (res_prenum)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire && in_term)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_ch_reg <= s_axis_tdata;
        if (fire && in_term)
        begin
            out_ok_reg   <= res_ok;
            out_data_reg <= {res_prenum, res_pretag, res_patch, res_minor, res_major};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

endmodule

>>> rtl/core/vsp_checker.sv
`include "version_string_parser_unit_assert.svh"

module vsp_checker #(
    parameter  int NUM_BITS = 16,
    localparam int OUT_W    = ((4 * NUM_BITS + 2 + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [7:0]       s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);
    import vsp_pkg::*;

    localparam int TAG_LO = 3 * NUM_BITS;

    logic       in_term;
    logic [1:0] out_tag;

    assign in_term = s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_NUL);
    assign out_tag = m_axis_tdata[TAG_LO+1:TAG_LO];

    // result word held until taken
    `VSP_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result word dropped while stalled")

    // failed parse carries all zero fields
    `VSP_ASSERT(a_fail_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "failed result has nonzero fields")

    // tag code is none, a or b
    `VSP_ASSERT(a_tag_code, clk, rst_n, m_axis_tvalid |-> out_tag != 2'd3, "illegal prerelease tag code")

    // an idle output turns valid only from a terminator word, through the input and result registers
    `VSP_ASSERT(a_rise_after_term, clk, rst_n, $rose(m_axis_tvalid) |-> $past(in_term, 2), "result word without terminator")

    `VSP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind version_string_parser_unit vsp_checker #(.NUM_BITS(NUM_BITS)) u_vsp_checker (.*);
